[src/autokey_vigenere_cipher_unit_assert.svh]
// assertion macros for the autokey vigenere cipher unit
// AVC_ASSERT checks a property with reset as disable condition
// AVC_ASSERT_ALWAYS checks a property at every rising clock edge, reset included
`ifndef AUTOKEY_VIGENERE_CIPHER_UNIT_ASSERT_SVH
`define AUTOKEY_VIGENERE_CIPHER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define AVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
`define AVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define AVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[src/avc_pkg.sv]
package avc_pkg;

    // item kinds
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    // configuration register indexes
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_KEY_LENGTH = 1'b1;

    // mode codes
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    localparam logic [4:0] LETTERS = 5'd26;
    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    typedef struct packed {
        logic       is_letter;
        logic [4:0] value;
    } t_letter;

    // classify a byte as a letter and give its alphabet position
    function automatic t_letter letter_value(input logic [7:0] b);
        t_letter l;
        l.is_letter = 1'b0;
        l.value     = '0;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            l.is_letter = 1'b1;
            l.value     = 5'(b - UPPER_A);
        end else if (b >= LOWER_A && b <= LOWER_Z) begin
            l.is_letter = 1'b1;
            l.value     = 5'(b - LOWER_A);
        end
        return l;
    endfunction

    // reduce a stored 5 bit letter into 0..25
    function automatic logic [4:0] mod26(input logic [4:0] x);
        return (x >= LETTERS) ? 5'(x - LETTERS) : x;
    endfunction

    // (a + b) mod 26 for a, b below 26
    function automatic logic [4:0] add_mod26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, LETTERS}) ? 5'(s - {1'b0, LETTERS}) : s[4:0];
    endfunction

    // (a - b) mod 26 for a, b below 26
    function automatic logic [4:0] sub_mod26(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, LETTERS} - {1'b0, b};
        return (s >= {1'b0, LETTERS}) ? 5'(s - {1'b0, LETTERS}) : s[4:0];
    endfunction

endpackage

[src/autokey_vigenere_cipher_unit.sv]
// autokey vigenere cipher over a byte stream. key transactions (kind 0) store a
// primer letter at key_index in the letter ring and send the ring pointer back
// to cell 0; they give no result. text transactions (kind 1) give exactly one
// result byte: a letter of either case is shifted by the ring letter at the
// pointer (added in encrypt mode, subtracted in decrypt mode) and comes out as
// an uppercase letter, after which the plaintext letter is stored back in that
// cell and the pointer steps on modulo key_length; any other byte passes
// through unchanged. the unit takes one transaction every clock cycle unless
// stage 1 holds a result that the stalled output register cannot take; each
// result is registered in stage 1 and then in the output register.
// the rate is set by the ring memory: one read and one write per cycle on a
// single synchronous memory, with a bypass path so that a letter stored by one
// item is seen by the next item even when both touch the same cell. ring cells
// hold garbage until a transaction writes them; the user writes configuration
// (mode, key_length) only while the unit is idle; the unit does not enforce it.
`include "autokey_vigenere_cipher_unit_assert.svh"

module autokey_vigenere_cipher_unit #(
    parameter int MAX_KEY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,

    // input transactions
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_text_byte,
    input  logic [4:0] i_key_letter,
    input  logic [4:0] i_key_index,

    // result transactions
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,

    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    // pointer width and a compare width that holds key_length and MAX_KEY
    localparam int PW = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
    localparam int CW = ((PW > 6) ? PW : 6) + 1;
    localparam logic [CW-1:0] MAX_KEY_C = CW'(MAX_KEY);

    // configuration registers
    logic          r_mode;
    logic [5:0]    r_key_length;

    // ring pointer, kept in step with accepted transactions
    logic [PW-1:0] r_ptr;
    logic [PW-1:0] n_ptr;

    // stage 1: transaction waiting on the ring read
    logic          r_s1_valid;
    logic          r_s1_text;
    logic          r_s1_letter;
    logic [4:0]    r_s1_value;
    logic [7:0]    r_s1_byte;
    logic [PW-1:0] r_s1_addr;
    logic [4:0]    r_s1_key_letter;
    logic          r_s1_key_ok;

    // output register
    logic          r_out_valid;
    logic [7:0]    r_out_byte;

    logic             w_in_accept;
    logic             w_s1_go;
    avc_pkg::t_letter w_letter;
    logic [CW-1:0]    w_used_len;
    logic [CW-1:0]    w_ptr_inc;
    logic             w_rd_en;
    logic [4:0]       w_rd_data;
    logic [4:0]       w_key;
    logic [4:0]       w_plain;
    logic [4:0]       w_res;
    logic             w_wr_en;
    logic [4:0]       w_wr_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= avc_pkg::MODE_ENCRYPT;
            r_key_length <= 6'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                avc_pkg::REG_MODE:       r_mode       <= i_cfg_data[0];
                avc_pkg::REG_KEY_LENGTH: r_key_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1 moves on unless it holds a result and the output register is stuck
    assign w_s1_go     = r_s1_valid && (!r_s1_text || !r_out_valid || !i_out_stall);
    assign o_in_stall  = r_s1_valid && !w_s1_go;
    assign w_in_accept = i_in_valid && !o_in_stall;

    assign w_letter = avc_pkg::letter_value(i_text_byte);

    // key length clamped to 1..MAX_KEY
    always_comb begin
        w_used_len = CW'(r_key_length);
        if (w_used_len == '0) begin
            w_used_len = CW'(1);
        end else if (w_used_len > MAX_KEY_C) begin
            w_used_len = MAX_KEY_C;
        end
    end

    assign w_ptr_inc = CW'(r_ptr) + CW'(1);

    // pointer: key transaction rewinds, letter steps with wrap
    always_comb begin
        n_ptr = r_ptr;
        if (w_in_accept) begin
            if (i_kind == avc_pkg::KIND_KEY) begin
                n_ptr = '0;
            end else if (w_letter.is_letter) begin
                n_ptr = (w_ptr_inc >= w_used_len) ? '0 : w_ptr_inc[PW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // ring read issued as a letter is taken
    assign w_rd_en = w_in_accept && (i_kind == avc_pkg::KIND_TEXT) && w_letter.is_letter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_text       <= (i_kind == avc_pkg::KIND_TEXT);
            r_s1_letter     <= w_letter.is_letter;
            r_s1_value      <= w_letter.value;
            r_s1_byte       <= i_text_byte;
            r_s1_addr       <= (i_kind == avc_pkg::KIND_TEXT) ? r_ptr : PW'(i_key_index);
            r_s1_key_letter <= i_key_letter;
            r_s1_key_ok     <= (CW'(i_key_index) < MAX_KEY_C);
        end
    end

    avc_ring #(
        .DEPTH (MAX_KEY)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_ptr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data)
    );

    // shift by the ring letter, plaintext goes back into the ring
    always_comb begin
        w_key = avc_pkg::mod26(w_rd_data);
        if (r_mode == avc_pkg::MODE_ENCRYPT) begin
            w_plain = r_s1_value;
            w_res   = avc_pkg::add_mod26(r_s1_value, w_key);
        end else begin
            w_plain = avc_pkg::sub_mod26(r_s1_value, w_key);
            w_res   = w_plain;
        end
    end

    // at most one write per item as it leaves stage 1: key letter or plaintext letter
    assign w_wr_en   = w_s1_go && (r_s1_text ? r_s1_letter : r_s1_key_ok);
    assign w_wr_data = r_s1_text ? w_plain : r_s1_key_letter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && r_s1_text) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && r_s1_text) begin
            r_out_byte <= r_s1_letter ? (8'(w_res) + avc_pkg::UPPER_A) : r_s1_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;

    // pointer never leaves the ring
    `AVC_ASSERT(a_ptr_in_ring, i_clk, i_rst_n, (int'(r_ptr) < MAX_KEY), "ring pointer beyond ring")
    // a key transaction rewinds the pointer
    `AVC_ASSERT(a_key_rewinds, i_clk, i_rst_n, (w_in_accept && (i_kind == avc_pkg::KIND_KEY)) |=> (r_ptr == '0), "pointer not rewound by key")
    // a text item leaving stage 1 always lands in the output register
    `AVC_ASSERT(a_text_to_out, i_clk, i_rst_n, (w_s1_go && r_s1_text) |=> r_out_valid, "text result lost")
    // a key item leaving stage 1 makes no result of its own
    `AVC_ASSERT(a_key_no_out, i_clk, i_rst_n, (w_s1_go && !r_s1_text && (!r_out_valid || !i_out_stall)) |=> !r_out_valid, "key item made a result")

endmodule

[src/avc_ring.sv]
// letter ring memory: one write and one read port, registered read,
// bypass of a write that lands on the entry read in the same cycle
module avc_ring #(
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [4:0]    o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [4:0]    i_wr_data
);

    logic [4:0] r_mem [DEPTH];
    logic [4:0] r_rd_data;
    logic       r_fwd;
    logic [4:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr_data;
        end
    end

    // read-before-write in the memory, so a colliding write is bypassed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : r_rd_data;

endmodule
